// ===== design/lz10_pkg.sv =====
// ----------------------------------------------------------------------------
// LZ10 decoder package
// Shared constants, payload structs and state encodings of the LZ10 decoder.
// ----------------------------------------------------------------------------
package lz10_pkg;

  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int unsigned CFG_W        = 24;
  localparam int unsigned MIN_MATCH    = 3;
  localparam int unsigned FLAG_COUNT   = 8;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_COPY = 3'b100
  } state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    status_e    status;
  } out_item_t;

endpackage

// ===== design/lz10_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// LZ10 stream decoder
// Headerless LZ10 (LZSS, 4096-byte window) decoder, one source byte per
// transfer, up to eighteen decoded bytes out per source byte.
// ----------------------------------------------------------------------------
// Each source byte is registered while the decoder is idle and worked on in
// the execute state once the output register is free; flag bytes, literals,
// first match bytes and bytes dropped after the end of a frame finish there.
// The second byte of a match starts a copy of 3 to 18 bytes through the
// single 4096 x 8 history RAM, one read and one write per cycle unless the
// output stalls; the history needs no clearing after reset. The user writes
// the frame length register only while idle; the decoder does not enforce it.
module lz10_stream_decoder import lz10_pkg::*; #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int unsigned LW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  state_e                state_q, state_d;
  logic [CFG_W-1:0]      cfg_len_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [7:0]            flags_q, flags_d;
  logic [3:0]            bits_q, bits_d;
  phase_e                phase_q, phase_d;
  logic [7:0]            held_q, held_d;
  status_e               status_q, status_d;
  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;
  logic [4:0]            rem_q, rem_d;
  logic [HIST_AW-1:0]    src_q, src_d;

  logic [COUNT_BITS-1:0] len_eff;
  logic [LW-1:0]         len_ext;
  logic [COUNT_BITS-1:0] cnt_inc;
  status_e               st_end;
  logic [3:0]            bits_dec;
  logic [4:0]            mlen;
  logic [HIST_AW:0]      back;
  logic                  bad_match;
  logic [HIST_AW-1:0]    src_start;

  logic                  hist_we, hist_re;
  logic [HIST_AW-1:0]    hist_waddr, hist_raddr;
  logic [7:0]            hist_wdata, hist_rdata;
  logic                  out_free, out_load;
  out_item_t             out_item;

  assign len_ext = LW'(cfg_len_q);
  assign len_eff = (len_ext < LW'({COUNT_BITS{1'b1}})) ? COUNT_BITS'(len_ext)
                                                        : {COUNT_BITS{1'b1}};
  assign cnt_inc  = count_q + COUNT_BITS'(1);
  assign st_end   = (cnt_inc >= len_eff) ? ST_DONE : (last_q ? ST_ERR : ST_RUN);
  assign bits_dec = (bits_q != 4'd0) ? bits_q - 4'd1 : 4'd0;

  assign mlen      = {1'b0, held_q[7:4]} + 5'(MIN_MATCH);
  assign back      = {1'b0, held_q[3:0], byte_q} + (HIST_AW + 1)'(1);
  assign bad_match = (COUNT_BITS'(back) > count_q) ||
                     (COUNT_BITS'(mlen) > (len_eff - count_q));
  assign src_start = count_q[HIST_AW-1:0] - back[HIST_AW-1:0];

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    flags_d    = flags_q;
    bits_d     = bits_q;
    phase_d    = phase_q;
    held_d     = held_q;
    status_d   = status_q;
    byte_d     = byte_q;
    last_d     = last_q;
    rem_d      = rem_q;
    src_d      = src_q;
    hist_we    = 1'b0;
    hist_waddr = count_q[HIST_AW-1:0];
    hist_wdata = byte_q;
    hist_re    = 1'b0;
    hist_raddr = src_q;
    out_load   = 1'b0;
    out_item   = '{out_byte: 8'd0, byte_valid: 1'b0, run_last: 1'b1, status: ST_RUN};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          byte_d  = in_data_i.in_byte;
          last_d  = in_data_i.in_last;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (status_q != ST_RUN) begin
            // drop
          end else if (count_q >= len_eff) begin
            out_load        = 1'b1;
            out_item.status = ST_DONE;
            status_d        = ST_DONE;
          end else begin
            unique case (phase_q)
              PH_TOKEN: begin
                if (!flags_q[7]) begin
                  hist_we           = 1'b1;
                  count_d           = cnt_inc;
                  flags_d           = {flags_q[6:0], 1'b0};
                  bits_d            = bits_dec;
                  phase_d           = (bits_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                  out_load          = 1'b1;
                  out_item.out_byte = byte_q;
                  out_item.byte_valid = 1'b1;
                  out_item.status   = st_end;
                  status_d          = st_end;
                end else begin
                  held_d  = byte_q;
                  phase_d = PH_SECOND;
                  if (last_q) begin
                    out_load        = 1'b1;
                    out_item.status = ST_ERR;
                  end
                end
              end
              PH_SECOND: begin
                if (bad_match) begin
                  out_load        = 1'b1;
                  out_item.status = ST_ERR;
                  status_d        = ST_ERR;
                end else begin
                  hist_re    = 1'b1;
                  hist_raddr = src_start;
                  src_d      = src_start + HIST_AW'(1);
                  rem_d      = mlen;
                  state_d    = S_COPY;
                end
              end
              default: begin
                flags_d = byte_q;
                bits_d  = 4'(FLAG_COUNT);
                phase_d = PH_TOKEN;
                if (last_q) begin
                  out_load        = 1'b1;
                  out_item.status = ST_ERR;
                end
              end
            endcase
          end
          // re-arm on the final source byte once the frame is over
          if (last_q && (status_d != ST_RUN || out_load)) begin
            count_d  = '0;
            flags_d  = 8'd0;
            bits_d   = 4'd0;
            phase_d  = PH_FLAG;
            held_d   = 8'd0;
            status_d = ST_RUN;
          end
          if (state_d == S_COPY) begin
            count_d  = count_q;
            flags_d  = flags_q;
            bits_d   = bits_q;
            phase_d  = phase_q;
            held_d   = held_q;
            status_d = status_q;
          end
        end
      end
      S_COPY: begin
        if (out_free) begin
          hist_we             = 1'b1;
          hist_wdata          = hist_rdata;
          count_d             = cnt_inc;
          rem_d               = rem_q - 5'd1;
          out_load            = 1'b1;
          out_item.out_byte   = hist_rdata;
          out_item.byte_valid = 1'b1;
          out_item.run_last   = 1'b0;
          if (rem_q == 5'd1) begin
            state_d           = S_IDLE;
            out_item.run_last = 1'b1;
            out_item.status   = st_end;
            flags_d           = {flags_q[6:0], 1'b0};
            bits_d            = bits_dec;
            phase_d           = (bits_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
            status_d          = st_end;
            if (last_q) begin
              count_d  = '0;
              flags_d  = 8'd0;
              bits_d   = 4'd0;
              phase_d  = PH_FLAG;
              held_d   = 8'd0;
              status_d = ST_RUN;
            end
          end else begin
            hist_re    = 1'b1;
            hist_raddr = src_q;
            src_d      = src_q + HIST_AW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_len_q <= CFG_W'(1);
      count_q   <= '0;
      flags_q   <= 8'd0;
      bits_q    <= 4'd0;
      phase_q   <= PH_FLAG;
      held_q    <= 8'd0;
      status_q  <= ST_RUN;
      rem_q     <= 5'd0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      flags_q  <= flags_d;
      bits_q   <= bits_d;
      phase_q  <= phase_d;
      held_q   <= held_d;
      status_q <= status_d;
      rem_q    <= rem_d;
      if (cfg_we_i) begin
        cfg_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    src_q  <= src_d;
  end

  lz10_hist_ram u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  lz10_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .item_i      (out_item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_copy_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY |-> rem_q != 5'd0)
    else $error("copy running with no bytes left");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_EXEC)
    else $error("accepted transfer not executed");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_item.status != ST_RUN |-> out_item.run_last)
    else $error("frame end on a result that is not the last of its input");

  a_hist_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> state_q != S_IDLE && out_load)
    else $error("history written without a decoded byte");

endmodule

// ===== design/lz10_hist_ram.sv =====
// ----------------------------------------------------------------------------
// LZ10 history RAM
// Single write port, single registered read port, write data forwarded on a
// same-address read.
// ----------------------------------------------------------------------------
module lz10_hist_ram import lz10_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [HIST_AW-1:0] waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic               re_i,
  input  logic [HIST_AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [WINDOW_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lz10_out_reg.sv =====
// ----------------------------------------------------------------------------
// LZ10 output register
// One-entry result register on the output channel.
// ----------------------------------------------------------------------------
module lz10_out_reg import lz10_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== tb/sv/lz10_decode_checker.sv =====
// ----------------------------------------------------------------------------
// LZ10 decode checker
// Watches the source, result and frame length ports of the LZ10 stream decoder.
// It decodes every accepted source byte itself, queues the decoded bytes it
// expects and compares each result transfer field by field with the oldest.
// ----------------------------------------------------------------------------
module lz10_decode_checker import lz10_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_CAP = 200;

  logic [7:0]       window_mem [WINDOW_DEPTH];
  logic [CFG_W-1:0] frame_len;
  logic [CFG_W-1:0] produced;
  logic [7:0]       flag_reg;
  logic [3:0]       flags_left;
  phase_e           parse_ph;
  logic [7:0]       match_hi;
  status_e          frame_st;
  out_item_t        decoded_q[$];
  int unsigned      fail_cnt = 0;

  function automatic void rearm_frame();
    produced   = '0;
    flag_reg   = '0;
    flags_left = '0;
    parse_ph   = PH_FLAG;
    match_hi   = '0;
    frame_st   = ST_RUN;
  endfunction

  function automatic void close_frame(status_e st, logic last);
    frame_st = st;
    if (last) begin
      rearm_frame();
    end
  endfunction

  function automatic void push_result(logic [7:0] b, logic vld, logic rl, status_e st);
    out_item_t r;
    r.out_byte   = b;
    r.byte_valid = vld;
    r.run_last   = rl;
    r.status     = st;
    decoded_q.push_back(r);
  endfunction

  function automatic void store_byte(logic [7:0] b);
    window_mem[produced[HIST_AW-1:0]] = b;
    produced = produced + 1'b1;
  endfunction

  function automatic void next_flag();
    flag_reg = flag_reg << 1;
    if (flags_left != 0) begin
      flags_left = flags_left - 1'b1;
    end
    parse_ph = (flags_left != 0) ? PH_TOKEN : PH_FLAG;
  endfunction

  function automatic status_e frame_outcome(logic last);
    if (produced >= frame_len) begin
      return ST_DONE;
    end
    return last ? ST_ERR : ST_RUN;
  endfunction

  function automatic void decode_byte(in_item_t it);
    logic [4:0]       mlen;
    logic [12:0]      back_dist;
    logic [CFG_W-1:0] src_at;
    logic [7:0]       v;
    status_e          st;
    int               k;
    if (frame_st != ST_RUN) begin
      if (it.in_last) begin
        rearm_frame();
      end
      return;
    end
    if (produced >= frame_len) begin
      push_result('0, 1'b0, 1'b1, ST_DONE);
      close_frame(ST_DONE, it.in_last);
      return;
    end
    case (parse_ph)
      PH_TOKEN: begin
        if (!flag_reg[7]) begin
          store_byte(it.in_byte);
          next_flag();
          st = frame_outcome(it.in_last);
          push_result(it.in_byte, 1'b1, 1'b1, st);
          if (st != ST_RUN) begin
            close_frame(st, it.in_last);
          end
        end else begin
          match_hi = it.in_byte;
          parse_ph = PH_SECOND;
          if (it.in_last) begin
            push_result('0, 1'b0, 1'b1, ST_ERR);
            close_frame(ST_ERR, 1'b1);
          end
        end
      end
      PH_SECOND: begin
        mlen = match_hi[7:4] + 5'(MIN_MATCH);
        back_dist = {1'b0, match_hi[3:0], it.in_byte} + 13'd1;
        if (back_dist > produced || mlen > frame_len - produced) begin
          push_result('0, 1'b0, 1'b1, ST_ERR);
          close_frame(ST_ERR, it.in_last);
        end else begin
          for (k = 0; k < mlen; k++) begin
            src_at = produced - back_dist;
            v = window_mem[src_at[HIST_AW-1:0]];
            store_byte(v);
            if (k == mlen - 1) begin
              next_flag();
              st = frame_outcome(it.in_last);
              push_result(v, 1'b1, 1'b1, st);
              if (st != ST_RUN) begin
                close_frame(st, it.in_last);
              end
            end else begin
              push_result(v, 1'b1, 1'b0, ST_RUN);
            end
          end
        end
      end
      default: begin
        flag_reg   = it.in_byte;
        flags_left = 4'(FLAG_COUNT);
        parse_ph   = PH_TOKEN;
        if (it.in_last) begin
          push_result('0, 1'b0, 1'b1, ST_ERR);
          close_frame(ST_ERR, 1'b1);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      rearm_frame();
      frame_len = CFG_W'(1);
      decoded_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_CAP) begin
            $display("%0t: result with none due: byte=%02h valid=%b last=%b status=%0d",
                     $time, out_data_i.out_byte, out_data_i.byte_valid,
                     out_data_i.run_last, out_data_i.status);
          end
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte ||
              out_data_i.byte_valid !== want.byte_valid ||
              out_data_i.run_last !== want.run_last ||
              out_data_i.status !== want.status) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_CAP) begin
              $display("%0t: expected byte=%02h valid=%b last=%b status=%0d, got byte=%02h valid=%b last=%b status=%0d",
                       $time, want.out_byte, want.byte_valid, want.run_last, want.status,
                       out_data_i.out_byte, out_data_i.byte_valid, out_data_i.run_last,
                       out_data_i.status);
            end
          end
        end
      end
      if (cfg_we_i) begin
        frame_len = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_data_i);
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= decoded_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// LZ10 stream decoder testbench
// Drives short directed streams covering literals, longest matches, bad
// distances and lengths, early ends and full frames, then a long frame that
// reaches back across the whole window and random frames, cut, corrupted and
// noisy, under random source gaps and result stalls. Checking is done by the
// decode checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lz10_pkg::*;

  localparam int unsigned RUN_LIMIT     = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 300;
  localparam int unsigned MAX_MATCH     = 18;
  localparam int unsigned LONG_FRAME    = 4400;

  typedef enum {FR_CLEAN, FR_CUT, FR_FLIP, FR_NOISE} frame_kind_e;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             src_valid = 1'b0;
  logic             src_stall;
  in_item_t         src_item  = '0;
  logic             dec_valid;
  logic             dec_stall = 1'b0;
  out_item_t        dec_item;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned stall_run   = 0;
  int unsigned free_run    = 0;
  logic        steady      = 1'b0;

  lz10_stream_decoder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (src_valid),
    .in_stall_o  (src_stall),
    .in_data_i   (src_item),
    .out_valid_o (dec_valid),
    .out_stall_i (dec_stall),
    .out_data_o  (dec_item)
  );

  lz10_decode_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (src_valid),
    .in_stall_i   (src_stall),
    .in_data_i    (src_item),
    .out_valid_i  (dec_valid),
    .out_stall_i  (dec_stall),
    .out_data_i   (dec_item),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("lz10_stream_decoder: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    int unsigned pick;
    if (stall_run != 0) begin
      stall_run--;
      dec_stall <= 1'b1;
    end else if (free_run != 0) begin
      free_run--;
      dec_stall <= 1'b0;
    end else begin
      pick      = $urandom_range(0, 99);
      stall_run = (pick < 8) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      free_run  = (pick >= 90) ? $urandom_range(60, 200) : $urandom_range(0, 4);
      dec_stall <= 1'b0;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 94) begin
        gap = $urandom_range(10, 40);
      end else if (r >= 60) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      @(negedge clk) src_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_item  <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (src_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // hold until every decoded byte due has arrived, then let the block settle
  task automatic drain();
    @(negedge clk) src_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned length, input frame_kind_e kind,
                            input int unsigned match_pct, input logic long_runs);
    logic [7:0]  src_q[$];
    logic [7:0]  toks[$];
    logic [7:0]  flag;
    logic [15:0] code;
    int unsigned made;
    int unsigned room;
    int unsigned mlen;
    int unsigned reach;
    int unsigned span;
    int unsigned i;
    int unsigned n;
    made = 0;
    while (made < length) begin
      flag = '0;
      toks.delete();
      for (i = 0; i < FLAG_COUNT && made < length; i++) begin
        room = length - made;
        if (made != 0 && room >= MIN_MATCH && $urandom_range(0, 99) < match_pct) begin
          mlen = (room < MAX_MATCH) ? room : MAX_MATCH;
          if (!long_runs && $urandom_range(0, 3) != 0) begin
            mlen = $urandom_range(MIN_MATCH, mlen);
          end
          reach = (made < WINDOW_DEPTH) ? made : WINDOW_DEPTH;
          case ($urandom_range(0, 3))
            0:       span = reach;
            1:       span = 1;
            default: span = $urandom_range(1, reach);
          endcase
          code = {4'(mlen - MIN_MATCH), 12'(span - 1)};
          flag[7 - i] = 1'b1;
          toks.push_back(code[15:8]);
          toks.push_back(code[7:0]);
          made += mlen;
        end else begin
          toks.push_back(8'($urandom_range(0, 255)));
          made++;
        end
      end
      src_q.push_back(flag);
      foreach (toks[j]) src_q.push_back(toks[j]);
    end
    case (kind)
      FR_CLEAN: begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) src_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      FR_CUT: begin
        n = $urandom_range(1, src_q.size() - 1);
        while (src_q.size() > n) void'(src_q.pop_back());
      end
      FR_FLIP: begin
        n = $urandom_range(0, src_q.size() - 1);
        src_q[n] ^= 8'($urandom_range(1, 255));
      end
      default: begin
        src_q.delete();
        repeat ($urandom_range(1, 12)) src_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    for (i = 0; i < src_q.size(); i++) begin
      push_byte(src_q[i], (i == src_q.size() - 1) ||
                          (kind == FR_NOISE && $urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    int unsigned len;
    int unsigned r;
    int unsigned base;
    int unsigned frame_no;
    frame_kind_e kind;
    len      = 1;
    frame_no = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // single-byte frame, then a flag byte that ends the source
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);

    // longest match at distance one, closed by a literal
    set_length(CFG_W'(20));
    push_byte(8'h40, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b1);

    // distance beyond the output so far; the rest is dropped
    push_byte(8'h40, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b1);

    // source ends on the first match byte
    push_byte(8'h80, 1'b0);
    push_byte(8'hF3, 1'b1);

    // frame length lowered below the output so far
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    set_length(CFG_W'(1));
    push_byte(8'h80, 1'b0);
    push_byte(8'h3C, 1'b1);

    // match longer than the bytes still due
    set_length(CFG_W'(10));
    push_byte(8'h40, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h00, 1'b1);

    // largest frame length, source ends early on a literal
    set_length(24'hFF_FFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);

    // long frame wrapping the window, with matches reaching the full window back
    set_length(CFG_W'(LONG_FRAME));
    send_frame(LONG_FRAME, FR_CLEAN, 95, 1'b1);

    base = bytes_sent;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      if (frame_no % 3 == 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          len = $urandom_range(1, 12);
        end else if (r < 85) begin
          len = $urandom_range(13, 60);
        end else begin
          len = $urandom_range(61, 300);
        end
        set_length(CFG_W'(len));
      end
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        kind = FR_CLEAN;
      end else if (r < 82) begin
        kind = FR_CUT;
      end else if (r < 94) begin
        kind = FR_FLIP;
      end else begin
        kind = FR_NOISE;
      end
      send_frame(len, kind, $urandom_range(20, 80), 1'b0);
      if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      frame_no++;
    end

    drain();
    if (fail_count == 0) begin
      $display("lz10_stream_decoder: match");
    end else begin
      $display("lz10_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule
